// File: rtl/ksc_pkg.sv
// ksc_pkg: shared types and constants for the keyword substitution cipher unit
// request codes, internal operation codes, the classified item and the back-end states
// no dependencies
package ksc_pkg;

    localparam int LETTERS     = 26;
    localparam int LETTER_W    = 5;
    localparam int CHAR_W      = 8;
    localparam int REQ_W       = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = 2;

    // request codes on the req_type port
    localparam logic [REQ_W-1:0] REQ_KEY_BEGIN = 3'd0;
    localparam logic [REQ_W-1:0] REQ_KEY_CHAR  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_KEY_END   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ENCRYPT   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DECRYPT   = 3'd4;

    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_CASE    = 8'h20;

    localparam logic [LETTER_W-1:0] LAST_LETTER = 5'd25;
    localparam logic [LETTER_W-1:0] FULL_COUNT  = 5'd26;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_BEGIN,
        OP_CHAR,
        OP_END,
        OP_ENC,
        OP_DEC
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic                is_letter;
        logic [LETTER_W-1:0] letter;
        logic [CHAR_W-1:0]   raw;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FILL,
        BK_DONE
    } back_state_t;

endpackage

// File: rtl/ksc_front.sv
// ksc_front: accepts request items and classifies them into commands for the queue
// decodes the request type, folds case and picks out letter indexes
// depends on ksc_pkg
module ksc_front (
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ksc_pkg::REQ_W-1:0]    req_type,
    input  logic [ksc_pkg::CHAR_W-1:0]   in_char,
    input  logic                         q_full,
    output logic                         push,
    output ksc_pkg::cmd_t                cmd
);

    logic                          is_upper;
    logic                          is_lower;
    logic [ksc_pkg::CHAR_W-1:0]    folded;
    logic [ksc_pkg::CHAR_W-1:0]    offset;
    ksc_pkg::op_t                  op;

    assign is_upper = (in_char >= ksc_pkg::CH_UPPER_A) && (in_char <= ksc_pkg::CH_UPPER_Z);
    assign is_lower = (in_char >= ksc_pkg::CH_LOWER_A) && (in_char <= ksc_pkg::CH_LOWER_Z);
    assign folded   = is_lower ? (in_char - ksc_pkg::CH_CASE) : in_char;
    assign offset   = folded - ksc_pkg::CH_UPPER_A;

    always_comb
    begin
        unique case (req_type)
            ksc_pkg::REQ_KEY_BEGIN: op = ksc_pkg::OP_BEGIN;
            ksc_pkg::REQ_KEY_CHAR:  op = ksc_pkg::OP_CHAR;
            ksc_pkg::REQ_KEY_END:   op = ksc_pkg::OP_END;
            ksc_pkg::REQ_ENCRYPT:   op = ksc_pkg::OP_ENC;
            ksc_pkg::REQ_DECRYPT:   op = ksc_pkg::OP_DEC;
            default:                op = ksc_pkg::OP_NOP;
        endcase
    end

    always_comb
    begin
        cmd.op  = op;
        cmd.raw = in_char;
        cmd.letter = offset[ksc_pkg::LETTER_W-1:0];
        // decrypt leaves lower case alone
        cmd.is_letter = (op == ksc_pkg::OP_DEC) ? is_upper : (is_upper || is_lower);
    end

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

endmodule

// File: rtl/ksc_queue.sv
// ksc_queue: short command queue between the front and back parts
// two entries, lets either side stall on its own
// depends on ksc_pkg
module ksc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ksc_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output ksc_pkg::cmd_t  head_cmd
);

    ksc_pkg::cmd_t                   entry_reg [ksc_pkg::QUEUE_DEPTH];
    logic [ksc_pkg::QUEUE_AW-1:0]    wr_ptr_reg;
    logic [ksc_pkg::QUEUE_AW-1:0]    wr_ptr_next;
    logic [ksc_pkg::QUEUE_AW-1:0]    rd_ptr_reg;
    logic [ksc_pkg::QUEUE_AW-1:0]    rd_ptr_next;
    logic [ksc_pkg::QUEUE_CW-1:0]    count_reg;
    logic [ksc_pkg::QUEUE_CW-1:0]    count_next;

    assign full       = (count_reg == ksc_pkg::QUEUE_CW'(ksc_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? (wr_ptr_reg + ksc_pkg::QUEUE_AW'(1)) : wr_ptr_reg;
        rd_ptr_next = pop  ? (rd_ptr_reg + ksc_pkg::QUEUE_AW'(1)) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + ksc_pkg::QUEUE_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - ksc_pkg::QUEUE_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ksc_pkg::QUEUE_CW'(ksc_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + ksc_pkg::QUEUE_CW'(1)))
        else $error("queue count did not grow on push");
`endif

endmodule

// File: rtl/ksc_back.sv
// ksc_back: carries out queued commands on the substitution tables
// holds forward and inverse maps, the used-letter mask, the fill count and the result register
// depends on ksc_pkg
module ksc_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            head_valid,
    input  ksc_pkg::cmd_t                   head_cmd,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ksc_pkg::CHAR_W-1:0]      out_char,
    output logic                            was_mapped,
    output logic [ksc_pkg::LETTER_W-1:0]    key_letters
);

    ksc_pkg::back_state_t            state_reg;
    ksc_pkg::back_state_t            state_next;

    logic [ksc_pkg::LETTER_W-1:0]    forward_map_reg [ksc_pkg::LETTERS];
    logic [ksc_pkg::LETTER_W-1:0]    inverse_map_reg [ksc_pkg::LETTERS];
    logic [ksc_pkg::LETTERS-1:0]     letter_used_reg;
    logic [ksc_pkg::LETTER_W-1:0]    fill_count_reg;
    logic [ksc_pkg::LETTER_W-1:0]    fill_count_next;
    logic [ksc_pkg::LETTER_W-1:0]    fill_k_reg;
    logic [ksc_pkg::LETTER_W-1:0]    fill_k_next;

    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [ksc_pkg::CHAR_W-1:0]      out_char_reg;
    logic                            was_mapped_reg;
    logic [ksc_pkg::LETTER_W-1:0]    key_letters_reg;

    logic                            out_free;
    logic                            clear;
    logic                            place_try;
    logic                            place_en;
    logic [ksc_pkg::LETTER_W-1:0]    place_k;
    logic                            load;
    logic [ksc_pkg::CHAR_W-1:0]      res_char;
    logic                            res_mapped;
    logic [ksc_pkg::CHAR_W-1:0]      fwd_char;
    logic [ksc_pkg::CHAR_W-1:0]      inv_char;

    assign out_free = !out_valid_reg || out_ready;
    assign pop      = head_valid && out_free && (state_reg == ksc_pkg::BK_IDLE);

    assign fwd_char = ksc_pkg::CH_UPPER_A
                    + {{(ksc_pkg::CHAR_W-ksc_pkg::LETTER_W){1'b0}}, forward_map_reg[head_cmd.letter]};
    assign inv_char = ksc_pkg::CH_UPPER_A
                    + {{(ksc_pkg::CHAR_W-ksc_pkg::LETTER_W){1'b0}}, inverse_map_reg[head_cmd.letter]};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ksc_pkg::BK_IDLE:
            begin
                if (pop && (head_cmd.op == ksc_pkg::OP_END))
                begin
                    state_next = ksc_pkg::BK_FILL;
                end
            end
            ksc_pkg::BK_FILL:
            begin
                if (fill_k_reg == ksc_pkg::LAST_LETTER)
                begin
                    state_next = ksc_pkg::BK_DONE;
                end
            end
            ksc_pkg::BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = ksc_pkg::BK_IDLE;
                end
            end
            default: state_next = ksc_pkg::BK_IDLE;
        endcase
    end

    // datapath control
    always_comb
    begin
        clear      = 1'b0;
        place_try  = 1'b0;
        place_k    = head_cmd.letter;
        load       = 1'b0;
        res_char   = '0;
        res_mapped = 1'b0;
        fill_k_next = fill_k_reg;
        unique case (state_reg)
            ksc_pkg::BK_IDLE:
            begin
                fill_k_next = '0;
                if (pop)
                begin
                    load = (head_cmd.op != ksc_pkg::OP_END);
                    unique case (head_cmd.op)
                        ksc_pkg::OP_BEGIN: clear = 1'b1;
                        ksc_pkg::OP_CHAR:  place_try = head_cmd.is_letter;
                        ksc_pkg::OP_ENC:
                        begin
                            res_char   = head_cmd.is_letter ? fwd_char : head_cmd.raw;
                            res_mapped = head_cmd.is_letter;
                        end
                        ksc_pkg::OP_DEC:
                        begin
                            res_char   = head_cmd.is_letter ? inv_char : head_cmd.raw;
                            res_mapped = head_cmd.is_letter;
                        end
                        default: ;
                    endcase
                end
            end
            ksc_pkg::BK_FILL:
            begin
                // alphabet walk, one letter a cycle
                place_try   = 1'b1;
                place_k     = fill_k_reg;
                fill_k_next = fill_k_reg + ksc_pkg::LETTER_W'(1);
            end
            ksc_pkg::BK_DONE:
            begin
                load = out_free;
            end
            default: ;
        endcase
    end

    assign place_en = place_try && (fill_count_reg < ksc_pkg::FULL_COUNT)
                    && !letter_used_reg[place_k];

    always_comb
    begin
        if (clear)
        begin
            fill_count_next = '0;
        end
        else if (place_en)
        begin
            fill_count_next = fill_count_reg + ksc_pkg::LETTER_W'(1);
        end
        else
        begin
            fill_count_next = fill_count_reg;
        end
    end

    assign out_valid_next = load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ksc_pkg::BK_IDLE;
            fill_k_reg      <= '0;
            fill_count_reg  <= ksc_pkg::FULL_COUNT;
            letter_used_reg <= '1;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < ksc_pkg::LETTERS; i++)
            begin
                forward_map_reg[i] <= ksc_pkg::LETTER_W'(i);
                inverse_map_reg[i] <= ksc_pkg::LETTER_W'(i);
            end
        end
        else
        begin
            state_reg      <= state_next;
            fill_k_reg     <= fill_k_next;
            fill_count_reg <= fill_count_next;
            out_valid_reg  <= out_valid_next;
            if (clear)
            begin
                letter_used_reg <= '0;
                for (int i = 0; i < ksc_pkg::LETTERS; i++)
                begin
                    forward_map_reg[i] <= '0;
                    inverse_map_reg[i] <= '0;
                end
            end
            else if (place_en)
            begin
                letter_used_reg[place_k]         <= 1'b1;
                forward_map_reg[fill_count_reg]  <= place_k;
                inverse_map_reg[place_k]         <= fill_count_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg    <= res_char;
            was_mapped_reg  <= res_mapped;
            key_letters_reg <= fill_count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign was_mapped  = was_mapped_reg;
    assign key_letters = key_letters_reg;

`ifndef ASSERT_OFF
    a_used_matches_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(letter_used_reg) == 32'(fill_count_reg))
        else $error("used-letter mask disagrees with fill count");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ksc_pkg::BK_FILL) |-> (fill_k_reg <= ksc_pkg::LAST_LETTER))
        else $error("alphabet walk past last letter");

    a_walk_fills_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ksc_pkg::BK_DONE) |-> (fill_count_reg == ksc_pkg::FULL_COUNT))
        else $error("table not full after key end");
`endif

endmodule

// File: rtl/keyword_substitution_cipher_unit.sv
// Keyword substitution cipher unit: builds a substitution alphabet from a keyword and then
// encrypts or decrypts text one byte per item, one result item per request item. Key begin,
// key char, encrypt and decrypt items stream through the back part at one item per cycle while
// the output is not stalled; key end walks the alphabet one letter a cycle and holds the back
// part until the walk is done. A two-entry command queue sits between the request decoder and
// the table logic, and results leave through an output register. After reset the mapping is
// the identity and the fill count reported in key_letters is 26.
// depends on ksc_pkg, ksc_front, ksc_queue, ksc_back
module keyword_substitution_cipher_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ksc_pkg::REQ_W-1:0]       req_type,
    input  logic [ksc_pkg::CHAR_W-1:0]      in_char,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ksc_pkg::CHAR_W-1:0]      out_char,
    output logic                            was_mapped,
    output logic [ksc_pkg::LETTER_W-1:0]    key_letters
);

    logic           q_full;
    logic           push;
    ksc_pkg::cmd_t  push_cmd;
    logic           pop;
    logic           head_valid;
    ksc_pkg::cmd_t  head_cmd;

    ksc_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .in_char  (in_char),
        .q_full   (q_full),
        .push     (push),
        .cmd      (push_cmd)
    );

    ksc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    ksc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .was_mapped  (was_mapped),
        .key_letters (key_letters)
    );

endmodule

// File: sim/testbench.sv
// testbench for keyword_substitution_cipher_unit: directed rows, then random key sessions and text
// checked item by item against an in-bench model of the substitution tables
// depends on ksc_pkg and the rtl of the unit
`timescale 1ns / 1ps

module testbench;
    import ksc_pkg::*;

    // request codes the unit does not use
    localparam logic [REQ_W-1:0] REQ_SPARE_5 = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS = 1850;
    localparam int DRAIN_CYCLES = 80;
    localparam int TIMEOUT_NS   = 1500000;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [CHAR_W-1:0]   ch;
        logic                mapped;
        logic [LETTER_W-1:0] count;
    } cipher_out_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [CHAR_W-1:0] ch;
        logic              typed;
        cipher_out_t       res;
    } dir_row_t;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [REQ_W-1:0]    req_type = '0;
    logic [CHAR_W-1:0]   in_char = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [CHAR_W-1:0]   out_char;
    logic                was_mapped;
    logic [LETTER_W-1:0] key_letters;

    // model of the substitution tables
    logic [LETTER_W-1:0] fwd_tbl [LETTERS];
    logic [LETTER_W-1:0] inv_tbl [LETTERS];
    logic [LETTERS-1:0]  used_mask;
    logic [LETTER_W-1:0] slots_filled;

    cipher_out_t cipher_out_q [$];
    dir_row_t    dir_rows [$];
    cipher_out_t blank_res = '0;

    int mismatches     = 0;
    int items_accepted = 0;
    int results_seen   = 0;
    int burst_left     = 0;

    int rx_mode       = 0;
    int rx_mode_left  = 0;
    int rx_hold_left  = 0;
    int rx_holds_done = 0;
    int rx_cycle      = 0;

    keyword_substitution_cipher_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .in_char     (in_char),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .was_mapped  (was_mapped),
        .key_letters (key_letters)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    task automatic place_letter(input logic [LETTER_W-1:0] k);
        if (slots_filled < FULL_COUNT && !used_mask[k])
        begin
            fwd_tbl[slots_filled] = k;
            inv_tbl[k] = slots_filled;
            used_mask[k] = 1'b1;
            slots_filled = slots_filled + LETTER_W'(1);
        end
    endtask

    task automatic predict_cipher(input logic [REQ_W-1:0] r, input logic [CHAR_W-1:0] c,
                                  output cipher_out_t res);
        logic [CHAR_W-1:0] folded;
        folded = (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - CH_CASE : c;
        res.ch = '0;
        res.mapped = 1'b0;
        case (r)
            REQ_KEY_BEGIN:
            begin
                for (int k = 0; k < LETTERS; k++)
                begin
                    fwd_tbl[k] = '0;
                    inv_tbl[k] = '0;
                end
                used_mask = '0;
                slots_filled = '0;
            end
            REQ_KEY_CHAR:
            begin
                if (folded >= CH_UPPER_A && folded <= CH_UPPER_Z)
                    place_letter(LETTER_W'(folded - CH_UPPER_A));
            end
            REQ_KEY_END:
            begin
                for (int k = 0; k < LETTERS; k++)
                    place_letter(LETTER_W'(k));
            end
            REQ_ENCRYPT:
            begin
                if (folded >= CH_UPPER_A && folded <= CH_UPPER_Z)
                begin
                    res.ch = CH_UPPER_A
                           + CHAR_W'(fwd_tbl[LETTER_W'(folded - CH_UPPER_A)]);
                    res.mapped = 1'b1;
                end
                else
                    res.ch = folded;
            end
            REQ_DECRYPT:
            begin
                // only upper case goes through the inverse table
                if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
                begin
                    res.ch = CH_UPPER_A + CHAR_W'(inv_tbl[LETTER_W'(c - CH_UPPER_A)]);
                    res.mapped = 1'b1;
                end
                else
                    res.ch = c;
            end
            default: ;
        endcase
        res.count = slots_filled;
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch in %s at result %0d: got %0h, expected %0h",
                 field, results_seen, got, want);
        mismatches++;
    endtask

    task automatic add_row(input logic [REQ_W-1:0] r, input logic [CHAR_W-1:0] c,
                           input logic typed, input logic [CHAR_W-1:0] ech,
                           input logic emap, input logic [LETTER_W-1:0] ecount);
        dir_row_t row;
        row.req = r;
        row.ch = c;
        row.typed = typed;
        row.res.ch = ech;
        row.res.mapped = emap;
        row.res.count = ecount;
        dir_rows.push_back(row);
    endtask

    // sender: bursts of items with random gaps, valid held until the handshake
    task automatic send_item(input logic [REQ_W-1:0] r, input logic [CHAR_W-1:0] c,
                             input logic typed, input cipher_out_t typed_res);
        cipher_out_t predicted;
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        req_type <= r;
        in_char <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_cipher(r, c, predicted);
        cipher_out_q.push_back(typed ? typed_res : predicted);
        burst_left--;
        items_accepted++;
    endtask

    function automatic logic [CHAR_W-1:0] random_letter();
        logic [CHAR_W-1:0] base;
        base = $urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A;
        return base + CHAR_W'($urandom_range(0, LETTERS - 1));
    endfunction

    function automatic logic [CHAR_W-1:0] random_text_byte();
        if ($urandom_range(0, 9) < 6)
            return random_letter();
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [REQ_W-1:0] random_text_req();
        return $urandom_range(0, 1) ? REQ_ENCRYPT : REQ_DECRYPT;
    endfunction

    initial
    begin : stimulus
        int kind;
        int len;
        for (int k = 0; k < LETTERS; k++)
        begin
            fwd_tbl[k] = LETTER_W'(k);
            inv_tbl[k] = LETTER_W'(k);
        end
        used_mask = '1;
        slots_filled = FULL_COUNT;

        // identity after reset, byte extremes and spare request codes
        add_row(REQ_ENCRYPT, CH_LOWER_A, 1'b1, CH_UPPER_A, 1'b1, FULL_COUNT);
        add_row(REQ_ENCRYPT, CH_LOWER_Z, 1'b1, CH_UPPER_Z, 1'b1, FULL_COUNT);
        add_row(REQ_DECRYPT, CH_LOWER_A + 8'd16, 1'b1, CH_LOWER_A + 8'd16, 1'b0, FULL_COUNT);
        add_row(REQ_ENCRYPT, 8'h00, 1'b1, 8'h00, 1'b0, FULL_COUNT);
        add_row(REQ_DECRYPT, 8'hFF, 1'b1, 8'hFF, 1'b0, FULL_COUNT);
        add_row(REQ_SPARE_5, CH_UPPER_A, 1'b1, 8'h00, 1'b0, FULL_COUNT);
        add_row(REQ_SPARE_7, 8'hFF, 1'b1, 8'h00, 1'b0, FULL_COUNT);
        add_row(REQ_KEY_END, 8'h00, 1'b1, 8'h00, 1'b0, FULL_COUNT);
        // empty table maps every letter to A
        add_row(REQ_KEY_BEGIN, 8'hFF, 1'b1, 8'h00, 1'b0, 5'd0);
        add_row(REQ_ENCRYPT, CH_UPPER_A + 8'd12, 1'b1, CH_UPPER_A, 1'b1, 5'd0);
        add_row(REQ_DECRYPT, CH_UPPER_Z, 1'b1, CH_UPPER_A, 1'b1, 5'd0);
        // repeated letter, case folding and non-letters in the keyword
        add_row(REQ_KEY_CHAR, CH_LOWER_Z, 1'b1, 8'h00, 1'b0, 5'd1);
        add_row(REQ_KEY_CHAR, CH_UPPER_Z, 1'b1, 8'h00, 1'b0, 5'd1);
        add_row(REQ_KEY_CHAR, CH_UPPER_A - 8'd1, 1'b1, 8'h00, 1'b0, 5'd1);
        add_row(REQ_KEY_CHAR, CH_UPPER_Z + 8'd1, 1'b1, 8'h00, 1'b0, 5'd1);
        add_row(REQ_KEY_CHAR, CH_LOWER_A + 8'd10, 1'b1, 8'h00, 1'b0, 5'd2);
        add_row(REQ_ENCRYPT, CH_UPPER_A + 8'd1, 1'b0, 8'h00, 1'b0, 5'd0);
        add_row(REQ_SPARE_6, 8'h80, 1'b0, 8'h00, 1'b0, 5'd0);
        add_row(REQ_KEY_END, 8'h00, 1'b1, 8'h00, 1'b0, FULL_COUNT);
        // key char on a full table is dropped
        add_row(REQ_KEY_CHAR, CH_LOWER_A + 8'd16, 1'b1, 8'h00, 1'b0, FULL_COUNT);
        add_row(REQ_ENCRYPT, CH_UPPER_A, 1'b0, 8'h00, 1'b0, 5'd0);
        add_row(REQ_ENCRYPT, CH_LOWER_A - 8'd1, 1'b1, CH_LOWER_A - 8'd1, 1'b0, FULL_COUNT);
        add_row(REQ_DECRYPT, CH_UPPER_A, 1'b0, 8'h00, 1'b0, 5'd0);
        add_row(REQ_ENCRYPT, CH_LOWER_Z + 8'd1, 1'b1, CH_LOWER_Z + 8'd1, 1'b0, FULL_COUNT);
        add_row(REQ_DECRYPT, 8'h80, 1'b1, 8'h80, 1'b0, FULL_COUNT);

        wait (rst_n);
        @(posedge clk);
        foreach (dir_rows[i])
            send_item(dir_rows[i].req, dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].res);

        while (items_accepted < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 60)
            begin
                // keyword, fill, then text
                send_item(REQ_KEY_BEGIN, CHAR_W'($urandom_range(0, 255)), 1'b0, blank_res);
                len = $urandom_range(1, 10);
                repeat (len)
                    send_item(REQ_KEY_CHAR, ($urandom_range(0, 99) < 85) ? random_letter()
                              : CHAR_W'($urandom_range(0, 255)), 1'b0, blank_res);
                send_item(REQ_KEY_END, CHAR_W'($urandom_range(0, 255)), 1'b0, blank_res);
                len = $urandom_range(4, 40);
                repeat (len)
                    send_item(random_text_req(), random_text_byte(), 1'b0, blank_res);
            end
            else if (kind < 70)
            begin
                // long keyword of letters, key end on half of these sessions, then text
                send_item(REQ_KEY_BEGIN, 8'h00, 1'b0, blank_res);
                len = $urandom_range(30, 60);
                repeat (len)
                    send_item(REQ_KEY_CHAR, random_letter(), 1'b0, blank_res);
                if ($urandom_range(0, 1))
                    send_item(REQ_KEY_END, 8'h00, 1'b0, blank_res);
                len = $urandom_range(4, 12);
                repeat (len)
                    send_item(random_text_req(), random_text_byte(), 1'b0, blank_res);
            end
            else if (kind < 85)
            begin
                // text on a table left half built
                send_item(REQ_KEY_BEGIN, 8'h00, 1'b0, blank_res);
                len = $urandom_range(0, 6);
                repeat (len)
                    send_item(REQ_KEY_CHAR, random_letter(), 1'b0, blank_res);
                len = $urandom_range(2, 12);
                repeat (len)
                    send_item(random_text_req(), random_text_byte(), 1'b0, blank_res);
            end
            else
            begin
                len = $urandom_range(5, 20);
                repeat (len)
                    send_item(REQ_W'($urandom_range(0, 7)), CHAR_W'($urandom_range(0, 255)),
                              1'b0, blank_res);
            end
        end
        in_valid <= 1'b0;

        while (cipher_out_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // receiver: changing stall patterns, plus two long hold-offs while the sender keeps going
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (rx_hold_left > 0)
        begin
            out_ready <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end
        else if ((rx_holds_done == 0 && items_accepted >= 500) ||
                 (rx_holds_done == 1 && items_accepted >= 1300))
        begin
            out_ready <= 1'b0;
            rx_hold_left <= HOLD_CYCLES;
            rx_holds_done <= rx_holds_done + 1;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode <= $urandom_range(0, 3);
                rx_mode_left <= $urandom_range(20, 200);
            end
            else
                rx_mode_left <= rx_mode_left - 1;
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= (rx_cycle % 3 != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cipher_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (cipher_out_q.size() == 0)
                report_mismatch("unexpected item", int'(out_char), 0);
            else
            begin
                want = cipher_out_q.pop_front();
                if (out_char !== want.ch)
                    report_mismatch("out_char", int'(out_char), int'(want.ch));
                if (was_mapped !== want.mapped)
                    report_mismatch("was_mapped", int'(was_mapped), int'(want.mapped));
                if (key_letters !== want.count)
                    report_mismatch("key_letters", int'(key_letters), int'(want.count));
            end
            results_seen++;
        end
    end

endmodule

// File: sim.f
rtl/ksc_pkg.sv
rtl/ksc_front.sv
rtl/ksc_queue.sv
rtl/ksc_back.sv
rtl/keyword_substitution_cipher_unit.sv
sim/testbench.sv
